// ----- sv/ertt_pkg.sv -----
// ----------------------------------------------------------------------------
// ertt_pkg
// Shared types and constants for the echo reply round-trip time tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package ertt_pkg;

  // Operation codes of the input channel
  typedef enum logic {
    OP_SEND  = 1'b0,
    OP_REPLY = 1'b1
  } op_t;

  // Configuration register indexes
  typedef enum logic {
    REG_ECHO_IDENT = 1'b0,
    REG_IP_V6      = 1'b1
  } reg_idx_t;

  localparam logic [7:0]  REPLY_TYPE_V4 = 8'd0;
  localparam logic [7:0]  REPLY_TYPE_V6 = 8'd129;
  localparam logic [15:0] COUNT_MAX     = 16'hFFFF;
  localparam logic [47:0] TOTAL_MAX     = 48'hFFFF_FFFF_FFFF;

  localparam int SLOTS_DEFAULT = 128;
  localparam int QUEUE_DEPTH   = 4;

  typedef struct packed {
    logic [15:0] echo_ident;
    logic        ip_v6;
  } cfg_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic        is_send;   // counts as a send
    logic        store_en;  // send with sequence in range
    logic        match;     // reply that updates statistics
    logic [31:0] time_us;
    logic [15:0] slot;      // sequence minus one
  } item_t;

endpackage

`default_nettype wire

// ----- sv/ertt_front.sv -----
// ----------------------------------------------------------------------------
// ertt_front
// Accepts input items and classifies them into send/store/match decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module ertt_front #(
  parameter int SLOTS = ertt_pkg::SLOTS_DEFAULT
) (
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_operation,
  input  wire logic [31:0]    in_time_us,
  input  wire logic [7:0]     in_msg_type,
  input  wire logic [15:0]    in_msg_ident,
  input  wire logic [15:0]    in_seq_number,
  input  wire ertt_pkg::cfg_t cfg,
  input  wire logic           q_full,
  input  wire logic           clr_busy,
  output logic                push,
  output ertt_pkg::item_t     push_item
);

  localparam logic [15:0] SLOTS_W = 16'(SLOTS);

  logic       in_range;
  logic       type_ok;
  logic [7:0] want_type;

  assign in_ready  = !q_full && !clr_busy;
  assign push      = in_valid && in_ready;

  assign in_range  = (in_seq_number != 16'd0) && (in_seq_number <= SLOTS_W);
  assign want_type = cfg.ip_v6 ? ertt_pkg::REPLY_TYPE_V6 : ertt_pkg::REPLY_TYPE_V4;
  assign type_ok   = (in_msg_type == want_type);

  always_comb begin
    push_item.is_send  = (in_operation == ertt_pkg::OP_SEND);
    push_item.store_en = (in_operation == ertt_pkg::OP_SEND) && in_range;
    push_item.match    = (in_operation == ertt_pkg::OP_REPLY) && type_ok &&
                         (in_msg_ident == cfg.echo_ident) && in_range;
    push_item.time_us  = in_time_us;
    push_item.slot     = in_seq_number - 16'd1;
  end

endmodule

`default_nettype wire

// ----- sv/ertt_queue.sv -----
// ----------------------------------------------------------------------------
// ertt_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ertt_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire ertt_pkg::item_t push_item,
  input  wire logic            pop,
  output ertt_pkg::item_t      pop_item,
  output logic                 full,
  output logic                 not_empty
);

  localparam int QD = ertt_pkg::QUEUE_DEPTH;
  localparam int PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int CW = $clog2(QD + 1);

  ertt_pkg::item_t entry_r [QD];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full      = (count_r == CW'(QD));
  assign not_empty = (count_r != '0);
  assign pop_item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- sv/ertt_back.sv -----
// ----------------------------------------------------------------------------
// ertt_back
// Timestamp store, RTT pipeline and statistics registers with result output.
// ----------------------------------------------------------------------------
`default_nettype none

module ertt_back #(
  parameter int SLOTS = ertt_pkg::SLOTS_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_not_empty,
  input  wire ertt_pkg::item_t q_item,
  output logic                 pop,
  output logic                 clr_busy,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 out_matched,
  output logic [31:0]          out_rtt_us,
  output logic [15:0]          out_sent_count,
  output logic [15:0]          out_received_count,
  output logic [31:0]          out_min_rtt_us,
  output logic [31:0]          out_max_rtt_us,
  output logic [47:0]          out_total_rtt_us
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [31:0]     mem [SLOTS];
  logic [AW-1:0]   addr;
  logic            advance;

  // clearing pass
  logic            clr_busy_r;
  logic [AW-1:0]   clr_addr_r;

  // stage 1: item plus stored send time
  logic            s1_valid_r;
  ertt_pkg::item_t s1_item_r;
  logic [31:0]     rdata_r;

  // stage 2: RTT
  logic            s2_valid_r;
  logic            s2_send_r;
  logic            s2_match_r;
  logic [31:0]     s2_rtt_r;

  // stage 3: result and statistics
  logic            out_valid_r;
  logic            out_matched_r;
  logic [31:0]     out_rtt_r;
  logic [15:0]     sent_r, sent_nxt;
  logic [15:0]     reply_r, reply_nxt;
  logic [31:0]     min_r, min_nxt;
  logic [31:0]     max_r, max_nxt;
  logic [47:0]     sum_r, sum_nxt;
  logic [48:0]     sum_add;

  assign addr     = q_item.slot[AW-1:0];
  assign advance  = !out_valid_r || out_ready;
  assign pop      = advance && q_not_empty && !clr_busy_r;
  assign clr_busy = clr_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(SLOTS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Store: one write port (clear or send), one registered read port.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (pop && q_item.store_en) begin
      mem[addr] <= q_item.time_us;
    end
    if (pop && q_item.match) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item_r  <= q_item;
      s2_send_r  <= s1_item_r.is_send;
      s2_match_r <= s1_item_r.match;
      s2_rtt_r   <= s1_item_r.time_us - rdata_r;
    end
  end

  // statistics update for the item leaving stage 2
  assign sum_add = {1'b0, sum_r} + 49'(s2_rtt_r);

  always_comb begin
    sent_nxt  = sent_r;
    reply_nxt = reply_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    sum_nxt   = sum_r;
    if (s2_valid_r && s2_send_r && (sent_r != ertt_pkg::COUNT_MAX)) begin
      sent_nxt = sent_r + 16'd1;
    end
    if (s2_valid_r && s2_match_r) begin
      if (reply_r != ertt_pkg::COUNT_MAX) begin
        reply_nxt = reply_r + 16'd1;
      end
      // first match sets the minimum unconditionally
      if ((reply_r == 16'd0) || (s2_rtt_r < min_r)) begin
        min_nxt = s2_rtt_r;
      end
      if (s2_rtt_r > max_r) begin
        max_nxt = s2_rtt_r;
      end
      sum_nxt = sum_add[48] ? ertt_pkg::TOTAL_MAX : sum_add[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      out_matched_r <= 1'b0;
      out_rtt_r     <= '0;
      sent_r        <= '0;
      reply_r       <= '0;
      min_r         <= '0;
      max_r         <= '0;
      sum_r         <= '0;
    end else if (advance) begin
      s1_valid_r    <= pop;
      s2_valid_r    <= s1_valid_r;
      out_valid_r   <= s2_valid_r;
      out_matched_r <= s2_match_r;
      out_rtt_r     <= s2_match_r ? s2_rtt_r : 32'd0;
      sent_r        <= sent_nxt;
      reply_r       <= reply_nxt;
      min_r         <= min_nxt;
      max_r         <= max_nxt;
      sum_r         <= sum_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_matched        = out_matched_r;
  assign out_rtt_us         = out_rtt_r;
  assign out_sent_count     = sent_r;
  assign out_received_count = reply_r;
  assign out_min_rtt_us     = min_r;
  assign out_max_rtt_us     = max_r;
  assign out_total_rtt_us   = sum_r;

endmodule

`default_nettype wire

// ----- sv/echo_reply_rtt_tracker.sv -----
// ----------------------------------------------------------------------------
// echo_reply_rtt_tracker
// Echo request/reply round-trip time statistics with an APB config port.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one transfer per send or reply event.
//   A send stores in_time_us in the slot of its 1-based sequence number; a
//   matching reply reads that slot and yields RTT = receive - send (mod 2^32).
//   Output channel (out_valid/out_ready): exactly one result transfer per
//   input transfer, in order, carrying match flag, RTT and the running
//   counts, min, max and saturating total after that item.
//   Path: queue, stage 1, stage 2, output register. Throughput: one item
//   per cycle while out_ready is high; an item uses one store port at most.
//   Config: APB writes at byte address 0 (echo identifier) and 4 (IPv6
//   select); pready is tied high. Write only while the block is idle.
//   Reset: rst_n (sync, low) clears statistics and config, then a clearing
//   pass zeroes every slot of the store, with in_ready held low.
//   Receiver stall: the back pipeline freezes while out_valid waits; the
//   front keeps taking items into a 4-entry queue until it fills.
// ----------------------------------------------------------------------------
`default_nettype none

module echo_reply_rtt_tracker #(
  parameter int SLOTS = ertt_pkg::SLOTS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [31:0] in_time_us,
  input  wire logic [7:0]  in_msg_type,
  input  wire logic [15:0] in_msg_ident,
  input  wire logic [15:0] in_seq_number,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_matched,
  output logic [31:0]      out_rtt_us,
  output logic [15:0]      out_sent_count,
  output logic [15:0]      out_received_count,
  output logic [31:0]      out_min_rtt_us,
  output logic [31:0]      out_max_rtt_us,
  output logic [47:0]      out_total_rtt_us,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  ertt_pkg::cfg_t     cfg_r;
  ertt_pkg::reg_idx_t reg_idx;
  logic               cfg_wr;

  ertt_pkg::item_t    push_item;
  ertt_pkg::item_t    q_item;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_not_empty;
  logic               clr_busy;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign reg_idx    = ertt_pkg::reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        ertt_pkg::REG_ECHO_IDENT: cfg_r.echo_ident <= cfg_pwdata[15:0];
        ertt_pkg::REG_IP_V6:      cfg_r.ip_v6      <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ertt_pkg::REG_ECHO_IDENT: cfg_prdata = {16'd0, cfg_r.echo_ident};
      ertt_pkg::REG_IP_V6:      cfg_prdata = {31'd0, cfg_r.ip_v6};
      default:                  cfg_prdata = '0;
    endcase
  end

  // ------------------------------------------------- front: accept/classify
  ertt_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_time_us    (in_time_us),
    .in_msg_type   (in_msg_type),
    .in_msg_ident  (in_msg_ident),
    .in_seq_number (in_seq_number),
    .cfg           (cfg_r),
    .q_full        (q_full),
    .clr_busy      (clr_busy),
    .push          (push),
    .push_item     (push_item)
  );

  // --------------------------------------------------- decoupling queue
  ertt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (q_item),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // ------------------------------------------- back: store and statistics
  ertt_back #(
    .SLOTS (SLOTS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_not_empty        (q_not_empty),
    .q_item             (q_item),
    .pop                (pop),
    .clr_busy           (clr_busy),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_matched        (out_matched),
    .out_rtt_us         (out_rtt_us),
    .out_sent_count     (out_sent_count),
    .out_received_count (out_received_count),
    .out_min_rtt_us     (out_min_rtt_us),
    .out_max_rtt_us     (out_max_rtt_us),
    .out_total_rtt_us   (out_total_rtt_us)
  );

`ifndef SYNTHESIS
  // a matched result always comes with a nonzero reply count
  a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_matched) |-> (out_received_count != 16'd0))
    else $error("matched result with zero reply count");

  // once any reply matched, min never exceeds max
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_received_count != 16'd0) |-> (out_min_rtt_us <= out_max_rtt_us))
    else $error("min RTT above max RTT");

  // an unmatched result reports zero RTT
  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_matched) |-> (out_rtt_us == 32'd0))
    else $error("unmatched result with nonzero RTT");

  // the send count never goes backward
  a_sent_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (out_sent_count >= $past(out_sent_count)))
    else $error("send count decreased");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/echo_reply_rtt_tracker_tb.sv -----
// ----------------------------------------------------------------------------
// echo_reply_rtt_tracker_tb
// Self-checking bench for the echo round-trip time tracker. A directed table
// covers reset state, slot range edges, timestamp wrap, duplicate replies and
// mismatching type or identifier. Random send/reply traffic follows under
// several register settings, then a short tail under the IPv6 reply code.
// Every result transfer is checked field by field against a bench-side model
// of the statistics or, for table rows that give one, a hand-computed result.
// ----------------------------------------------------------------------------
`default_nettype none

module echo_reply_rtt_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRACK_SLOTS      = ertt_pkg::SLOTS_DEFAULT;
  localparam int SLOT_AW          = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
  localparam int RANDOM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE  = 300;
  localparam int TAIL_ITEMS       = 40;
  localparam int DRAIN_SLACK      = 20;

  // one input transfer
  typedef struct packed {
    ertt_pkg::op_t op;
    logic [31:0]   time_us;
    logic [7:0]    msg_type;
    logic [15:0]   msg_ident;
    logic [15:0]   seq;
  } echo_item_t;

  // one result transfer
  typedef struct packed {
    logic        matched;
    logic [31:0] rtt_us;
    logic [15:0] sent_count;
    logic [15:0] received_count;
    logic [31:0] min_rtt_us;
    logic [31:0] max_rtt_us;
    logic [47:0] total_rtt_us;
  } echo_stats_t;

  typedef struct {
    echo_item_t  item;
    bit          typed;   // want holds a hand-computed result
    echo_stats_t want;
  } directed_row_t;

  // DUT ports
  logic        clk;
  logic        rst_n         = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic        in_operation  = 1'b0;
  logic [31:0] in_time_us    = '0;
  logic [7:0]  in_msg_type   = '0;
  logic [15:0] in_msg_ident  = '0;
  logic [15:0] in_seq_number = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic        out_matched;
  logic [31:0] out_rtt_us;
  logic [15:0] out_sent_count;
  logic [15:0] out_received_count;
  logic [31:0] out_min_rtt_us;
  logic [31:0] out_max_rtt_us;
  logic [47:0] out_total_rtt_us;
  logic        cfg_psel      = 1'b0;
  logic        cfg_penable   = 1'b0;
  logic        cfg_pwrite    = 1'b0;
  logic [2:0]  cfg_paddr     = '0;
  logic [31:0] cfg_pwdata    = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Bench copy of the tracker state and its registers
  logic [31:0] slot_send_time [TRACK_SLOTS] = '{default: 32'd0};
  logic [15:0] sends_seen     = '0;
  logic [15:0] replies_seen   = '0;
  logic [31:0] rtt_low        = '0;
  logic [31:0] rtt_high       = '0;
  logic [47:0] rtt_total      = '0;
  logic [15:0] cfg_echo_ident = '0;
  logic        cfg_ip_v6      = 1'b0;

  echo_stats_t   pending_stats [$];   // results owed by the DUT, oldest first
  directed_row_t directed_plan [$];
  int            mismatch_count = 0;
  int            tx_idle_pct    = 0;  // chance per cycle that the sender holds off
  int            rx_idle_pct    = 0;  // chance per cycle that out_ready is low

  echo_reply_rtt_tracker dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_time_us         (in_time_us),
    .in_msg_type        (in_msg_type),
    .in_msg_ident       (in_msg_ident),
    .in_seq_number      (in_seq_number),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_matched        (out_matched),
    .out_rtt_us         (out_rtt_us),
    .out_sent_count     (out_sent_count),
    .out_received_count (out_received_count),
    .out_min_rtt_us     (out_min_rtt_us),
    .out_max_rtt_us     (out_max_rtt_us),
    .out_total_rtt_us   (out_total_rtt_us),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a transfer never completes.
  // Slowest legal run is well under 2 ms; this allows ten times that.
  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // Store index of a 1-based sequence number
  function automatic logic [SLOT_AW-1:0] slot_index(logic [15:0] seq);
    return SLOT_AW'(seq - 16'd1);
  endfunction

  // --------------------------------------------------------------------------
  // Statistics model: applies one accepted item, returns the result it owes.
  // --------------------------------------------------------------------------
  function automatic echo_stats_t track_echo(echo_item_t it);
    echo_stats_t res;
    logic        in_range;
    logic [7:0]  reply_code;
    logic [48:0] sum_ext;
    res        = '0;
    in_range   = (it.seq != 16'd0) && (it.seq <= TRACK_SLOTS);
    reply_code = cfg_ip_v6 ? ertt_pkg::REPLY_TYPE_V6 : ertt_pkg::REPLY_TYPE_V4;
    if (it.op == ertt_pkg::OP_SEND) begin
      // out-of-range sends still count, they just store nothing
      if (in_range) slot_send_time[slot_index(it.seq)] = it.time_us;
      if (sends_seen != ertt_pkg::COUNT_MAX) sends_seen++;
    end else if (it.msg_type == reply_code && it.msg_ident == cfg_echo_ident &&
                 in_range) begin
      res.matched = 1'b1;
      res.rtt_us  = it.time_us - slot_send_time[slot_index(it.seq)];  // wraps mod 2^32
      // first match seeds the minimum whatever it held
      if (replies_seen == '0 || res.rtt_us < rtt_low) rtt_low = res.rtt_us;
      if (res.rtt_us > rtt_high) rtt_high = res.rtt_us;
      if (replies_seen != ertt_pkg::COUNT_MAX) replies_seen++;
      sum_ext   = {1'b0, rtt_total} + res.rtt_us;
      rtt_total = (sum_ext > ertt_pkg::TOTAL_MAX) ? ertt_pkg::TOTAL_MAX : sum_ext[47:0];
    end
    res.sent_count     = sends_seen;
    res.received_count = replies_seen;
    res.min_rtt_us     = rtt_low;
    res.max_rtt_us     = rtt_high;
    res.total_rtt_us   = rtt_total;
    return res;
  endfunction

  // Sequence number outside 1..SLOTS
  function automatic logic [15:0] off_range_seq();
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return 16'(TRACK_SLOTS + 1);
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(TRACK_SLOTS + 1, 65535));
    endcase
  endfunction

  // Random traffic: mostly sends and well-formed replies, often to hot slots,
  // plus near-miss replies and fully random noise.
  function automatic echo_item_t make_echo_item();
    echo_item_t it;
    int         pick;
    pick         = $urandom_range(99);
    it.op        = ertt_pkg::OP_REPLY;
    it.time_us   = $urandom;
    it.msg_type  = 8'($urandom);
    it.msg_ident = 16'($urandom);
    // a few hot slots so replies often find a real send time
    it.seq = ($urandom_range(1) != 0) ? 16'($urandom_range(1, 8))
                                      : 16'($urandom_range(1, TRACK_SLOTS));
    if (pick < 35) begin
      it.op = ertt_pkg::OP_SEND;
      if (pick < 4) it.seq = off_range_seq();
    end else if (pick < 85) begin
      it.msg_type  = cfg_ip_v6 ? ertt_pkg::REPLY_TYPE_V6 : ertt_pkg::REPLY_TYPE_V4;
      it.msg_ident = cfg_echo_ident;
      case ($urandom_range(3))
        0:       it.time_us = slot_send_time[slot_index(it.seq)];      // zero RTT
        1, 2:    it.time_us = slot_send_time[slot_index(it.seq)] +
                              $urandom_range(1, 5000);
        default: ;                                                    // any RTT, wraps
      endcase
      // near misses: break exactly one of the match conditions
      if (pick >= 72) begin
        case ($urandom_range(2))
          0: it.msg_type = ($urandom_range(1) != 0)
                           ? (cfg_ip_v6 ? ertt_pkg::REPLY_TYPE_V4 : ertt_pkg::REPLY_TYPE_V6)
                           : 8'($urandom);
          1: it.msg_ident = it.msg_ident ^ 16'(1 << $urandom_range(15));
          default: it.seq = off_range_seq();
        endcase
      end
    end else begin
      it.op  = ertt_pkg::op_t'($urandom_range(1));
      it.seq = 16'($urandom);
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: optional hold-off, then present and wait for the transfer.
  // in_valid stays high into the next item unless that item holds off first.
  // --------------------------------------------------------------------------
  task automatic transfer_item(echo_item_t it, bit typed, echo_stats_t want);
    echo_stats_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_operation  <= it.op;
    in_time_us    <= it.time_us;
    in_msg_type   <= it.msg_type;
    in_msg_ident  <= it.msg_ident;
    in_seq_number <= it.seq;
    do @(posedge clk); while (!in_ready);
    predicted = track_echo(it);
    pending_stats.push_back(typed ? want : predicted);
  endtask

  // Stop sending and wait until every owed result has come back
  task automatic wait_stats_drained();
    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic cfg_write(ertt_pkg::reg_idx_t idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == ertt_pkg::REG_ECHO_IDENT) cfg_echo_ident = value[15:0];
    else cfg_ip_v6 = value[0];
  endtask

  task automatic add_row(ertt_pkg::op_t op, logic [31:0] t, logic [7:0] msg_type,
                         logic [15:0] ident, logic [15:0] seq,
                         bit typed = 1'b0, echo_stats_t want = '0);
    directed_row_t row;
    row.item  = '{op, t, msg_type, ident, seq};
    row.typed = typed;
    row.want  = want;
    directed_plan.push_back(row);
  endtask

  task automatic check_field(string field, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatch_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: random backpressure and the result scoreboard
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : result_check
    echo_stats_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        $error("result transfer with nothing outstanding");
        mismatch_count++;
      end else begin
        want = pending_stats.pop_front();
        check_field("matched",        48'(want.matched),        48'(out_matched));
        check_field("rtt_us",         48'(want.rtt_us),         48'(out_rtt_us));
        check_field("sent_count",     48'(want.sent_count),     48'(out_sent_count));
        check_field("received_count", 48'(want.received_count), 48'(out_received_count));
        check_field("min_rtt_us",     48'(want.min_rtt_us),     48'(out_min_rtt_us));
        check_field("max_rtt_us",     48'(want.max_rtt_us),     48'(out_max_rtt_us));
        check_field("total_rtt_us",   want.total_rtt_us,        out_total_rtt_us);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [15:0] ident;
    logic        v6;

    // Directed table, run with the reset register values (ident 0, IPv4).
    // Hand-computed results only where the numbers are obvious.
    // slot never sent
    add_row(ertt_pkg::OP_REPLY, 32'd100, ertt_pkg::REPLY_TYPE_V4, 16'h0000, 16'd1, 1'b1,
            '{1'b1, 32'd100, 16'd0, 16'd1, 32'd100, 32'd100, 48'd100});
    // type/ident ignored
    add_row(ertt_pkg::OP_SEND, 32'd1000, 8'hFF, 16'hFFFF, 16'd1, 1'b1,
            '{1'b0, 32'd0, 16'd1, 16'd1, 32'd100, 32'd100, 48'd100});
    add_row(ertt_pkg::OP_REPLY, 32'd1500, ertt_pkg::REPLY_TYPE_V4, 16'h0000, 16'd1, 1'b1,
            '{1'b1, 32'd500, 16'd1, 16'd2, 32'd100, 32'd500, 48'd600});
    // duplicate reply
    add_row(ertt_pkg::OP_REPLY, 32'd1700, ertt_pkg::REPLY_TYPE_V4, 16'h0000, 16'd1);
    // out-of-range sends (seq 0, SLOTS+1, FFFF): count only
    add_row(ertt_pkg::OP_SEND, 32'hFFFF_FFFF, 8'h00, 16'h0000, 16'd0);
    add_row(ertt_pkg::OP_SEND, 32'd5, 8'h00, 16'h0000, 16'(TRACK_SLOTS + 1));
    add_row(ertt_pkg::OP_SEND, 32'd0, 8'h00, 16'h0000, 16'hFFFF);
    // top slot, then a reply that wraps
    add_row(ertt_pkg::OP_SEND, 32'hFFFF_FFF0, 8'h00, 16'h0000, 16'(TRACK_SLOTS));
    add_row(ertt_pkg::OP_REPLY, 32'h0000_0010, ertt_pkg::REPLY_TYPE_V4, 16'h0000,
            16'(TRACK_SLOTS));
    // seq 0, SLOTS+1 or FFFF never matches
    add_row(ertt_pkg::OP_REPLY, 32'd42, ertt_pkg::REPLY_TYPE_V4, 16'h0000, 16'd0, 1'b1,
            '{1'b0, 32'd0, 16'd5, 16'd4, 32'd32, 32'd700, 48'd1332});
    add_row(ertt_pkg::OP_REPLY, 32'd42, ertt_pkg::REPLY_TYPE_V4, 16'h0000,
            16'(TRACK_SLOTS + 1));
    add_row(ertt_pkg::OP_REPLY, 32'd42, ertt_pkg::REPLY_TYPE_V4, 16'h0000, 16'hFFFF);
    // wrong IP version, then an unknown type
    add_row(ertt_pkg::OP_REPLY, 32'd42, ertt_pkg::REPLY_TYPE_V6, 16'h0000, 16'd1);
    add_row(ertt_pkg::OP_REPLY, 32'd42, 8'hFF, 16'h0000, 16'd1);
    // wrong identifier
    add_row(ertt_pkg::OP_REPLY, 32'd42, ertt_pkg::REPLY_TYPE_V4, 16'hFFFF, 16'd1);
    // largest RTT
    add_row(ertt_pkg::OP_SEND, 32'd0, 8'h00, 16'h0000, 16'd2);
    add_row(ertt_pkg::OP_REPLY, 32'hFFFF_FFFF, ertt_pkg::REPLY_TYPE_V4, 16'h0000, 16'd2);
    // zero RTT, new min
    add_row(ertt_pkg::OP_SEND, 32'hAAAA_AAAA, 8'h55, 16'hA5A5, 16'd64);
    add_row(ertt_pkg::OP_REPLY, 32'hAAAA_AAAA, ertt_pkg::REPLY_TYPE_V4, 16'h0000, 16'd64);
    // cleared slot
    add_row(ertt_pkg::OP_REPLY, 32'h5555_5555, ertt_pkg::REPLY_TYPE_V4, 16'h0000, 16'd3);

    // Sender idles lightly, receiver stalls heavily for the first third
    tx_idle_pct = 23;
    rx_idle_pct = 73;

    // Reset once. In-ready stays low through the store clearing pass;
    // the first transfer simply waits for it.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i])
      transfer_item(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // idling: light/heavy, then swapped, then none
      if (phase == 2) begin
        tx_idle_pct = 73;
        rx_idle_pct = 23;
      end
      if (phase == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (phase)
        0:       begin ident = 16'hFFFF;       v6 = 1'b1; end
        2:       begin ident = 16'h0000;       v6 = 1'b1; end
        3:       begin ident = 16'($urandom);  v6 = 1'b1; end
        5:       begin ident = 16'hFFFF;       v6 = 1'b0; end
        default: begin ident = 16'($urandom);  v6 = 1'b0; end
      endcase
      // registers only change with the pipeline empty; upper bits are don't-care
      wait_stats_drained();
      cfg_write(ertt_pkg::REG_ECHO_IDENT, {16'($urandom), ident});
      cfg_write(ertt_pkg::REG_IP_V6, {31'($urandom), v6});
      repeat (ITEMS_PER_PHASE) transfer_item(make_echo_item(), 1'b0, '0);
    end

    // Short tail under the IPv6 reply code with a fresh identifier
    wait_stats_drained();
    cfg_write(ertt_pkg::REG_ECHO_IDENT, $urandom);
    cfg_write(ertt_pkg::REG_IP_V6, 32'd1);
    repeat (TAIL_ITEMS) transfer_item(make_echo_item(), 1'b0, '0);

    wait_stats_drained();
    repeat (DRAIN_SLACK) @(posedge clk);   // catch any stray result transfer

    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
sv/ertt_pkg.sv
sv/ertt_front.sv
sv/ertt_queue.sv
sv/ertt_back.sv
sv/echo_reply_rtt_tracker.sv
tb/sv/echo_reply_rtt_tracker_tb.sv
